### rtl/fnpd_pkg.sv
// Shared types and constants for the fractional-N divider calculator.
// Used by every module of the block; depends on nothing.
package fnpd_pkg;

   // Configuration register indexes.
   localparam logic CSR_PFD_HZ = 1'b0;
   localparam logic CSR_MOD2   = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [26:0] PFD_HZ_RESET = 27'd10000000;
   localparam logic [13:0] MOD2_RESET   = 14'd16383;

   // Band edges in hertz.
   localparam logic [33:0] BAND_LOW_HZ   = 34'd53125000;
   localparam logic [33:0] DOUBLER_LO_HZ = 34'd6800000000;
   localparam logic [33:0] BAND_HIGH_HZ  = 34'd13600000000;

   // Control word constants.
   localparam logic [31:0] R0_AUTOCAL = 32'h0020_0000;
   localparam logic [31:0] R1_ADDR    = 32'h0000_0001;
   localparam logic [31:0] R2_ADDR    = 32'h0000_0002;

   // Quotient bits of each division phase.
   localparam int INT_BITS   = 16;
   localparam int FRAC2_BITS = 14;
   localparam int QUO_BITS   = INT_BITS + 24 + FRAC2_BITS;

   // One item as it moves through the divider pipeline.
   typedef struct packed {
      logic                valid;
      logic                oor;
      logic                dbl;
      logic [2:0]          sel;
      logic [27:0]         rem;   // running remainder, below pfd2 unless oor is set
      logic [15:0]         num;   // numerator bits still to shift in, msb first
      logic [QUO_BITS-1:0] quo;   // quotient bits collected so far
   } item_type;

endpackage

### rtl/fractional_n_pll_divider_calc.sv
// Top level of the fractional-N divider calculator.
// Depends on fnpd_pkg, fnpd_band, fnpd_div_step and fnpd_mul.
//
// Usage:
//   A beat on req_ carries a wanted output frequency in hertz. One beat on
//   rsp_ comes back for each, in order, with INT, FRAC1, FRAC2, the divider
//   code, the doubler and feedback flags and the packed R0, R1, R2 words.
//   rsp_tuser flags a request that is out of range; all other fields are
//   then zero.
//   The csr_ port writes pfd_hz (index 0) and mod2 (index 1); write them
//   only while no request is in flight.
// Pipeline:
//   One band stage, 16 + FRAC1_BITS division steps, one multiply stage,
//   14 division steps and the output register. Each division stage
//   resolves one quotient bit with one compare and subtract. A new beat is
//   taken every cycle while the output is not stalled.
// Reset:
//   Clears all pipeline valid bits and loads pfd_hz = 10 MHz, mod2 = 16383.
// Stall:
//   When the output holds a beat that is not taken, the whole pipeline
//   freezes and req_tready drops; nothing is lost or repeated.
module fractional_n_pll_divider_calc
   import fnpd_pkg::*;
#(
   parameter int FRAC1_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel. tdata: output_frequency_hz[33:0], zero pad.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,
   // Result channel. tdata: int_value, frac1, frac2, divider_select,
   // doubler_on, feedback_fundamental, word_r0, word_r1, word_r2, zero pad.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,
   // tuser: out_of_range.
   output logic         rsp_tuser,
   // Configuration write port.
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [26:0]  csr_wdata
);

   localparam int NA = INT_BITS + FRAC1_BITS;

   logic [26:0]  pfd_hz_ff;
   logic [13:0]  mod2_ff;
   logic [27:0]  pfd2;
   logic         adv;
   item_type     stage_a [0:NA];
   item_type     stage_b [0:FRAC2_BITS];
   item_type     last;
   logic [15:0]  int_value;
   logic [23:0]  frac1;
   logic [13:0]  frac2;
   logic [159:0] tdata_in;
   logic         tuser_in;
   logic         out_valid_ff;
   logic [159:0] out_data_ff;
   logic         out_user_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pfd_hz_ff <= PFD_HZ_RESET;
         mod2_ff   <= MOD2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PFD_HZ: pfd_hz_ff <= csr_wdata;
            CSR_MOD2:   mod2_ff   <= csr_wdata[13:0];
            default:    pfd_hz_ff <= pfd_hz_ff;
         endcase
      end
   end

   assign pfd2       = {pfd_hz_ff, 1'b0};
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Band selection stage.
   fnpd_band u_band (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_tvalid),
      .freq     (req_tdata[33:0]),
      .pfd2     (pfd2),
      .item_ff  (stage_a[0])
   );

   // INT and FRAC1 quotient bits.
   for (genvar i = 0; i < NA; i++) begin : g_int_frac1
      fnpd_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .item_i  (stage_a[i]),
         .pfd2    (pfd2),
         .item_ff (stage_a[i+1])
      );
   end

   // Leftover times mod2.
   fnpd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .item_i  (stage_a[NA]),
      .mod2    (mod2_ff),
      .item_ff (stage_b[0])
   );

   // FRAC2 quotient bits.
   for (genvar j = 0; j < FRAC2_BITS; j++) begin : g_frac2
      fnpd_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .item_i  (stage_b[j]),
         .pfd2    (pfd2),
         .item_ff (stage_b[j+1])
      );
   end

   assign last = stage_b[FRAC2_BITS];

   // Unpack the quotient and build the result beat.
   always_comb begin
      frac2     = last.quo[FRAC2_BITS-1:0];
      frac1     = 24'(last.quo[FRAC2_BITS +: FRAC1_BITS]);
      int_value = last.quo[FRAC2_BITS+FRAC1_BITS +: INT_BITS];
      tdata_in  = '0;
      tuser_in  = last.oor;
      if (!last.oor) begin
         tdata_in[15:0]    = int_value;
         tdata_in[39:16]   = frac1;
         tdata_in[53:40]   = frac2;
         tdata_in[56:54]   = last.sel;
         tdata_in[57]      = last.dbl;
         tdata_in[58]      = !last.dbl;
         tdata_in[90:59]   = R0_AUTOCAL | {12'b0, int_value, 4'b0};
         tdata_in[122:91]  = R1_ADDR | {4'b0, frac1, 4'b0};
         tdata_in[154:123] = R2_ADDR | {frac2, mod2_ff, 4'b0};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= last.valid;
      end
      if (adv) begin
         out_data_ff <= tdata_in;
         out_user_ff <= tuser_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

### rtl/fnpd_band.sv
// Entry stage: band selection, range check and first remainder of INT.
// Depends on fnpd_pkg.
module fnpd_band
   import fnpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [33:0] freq,
   input  logic [27:0] pfd2,
   output item_type    item_ff
);

   logic [2:0]  cnt;
   logic [2:0]  sel;
   logic        in_band;
   logic        dbl;
   logic [33:0] vco2;
   logic        ovf;
   item_type    item_in;

   // Count the octave edges at or below the frequency to pick the divider.
   always_comb begin
      cnt = {2'b0, freq >= (BAND_LOW_HZ << 1)} + {2'b0, freq >= (BAND_LOW_HZ << 2)}
          + {2'b0, freq >= (BAND_LOW_HZ << 3)} + {2'b0, freq >= (BAND_LOW_HZ << 4)}
          + {2'b0, freq >= (BAND_LOW_HZ << 5)} + {2'b0, freq >= (BAND_LOW_HZ << 6)};
      sel     = 3'd6 - cnt;
      in_band = (freq >= BAND_LOW_HZ) && (freq <= BAND_HIGH_HZ);
      dbl     = freq >= DOUBLER_LO_HZ;
      vco2    = dbl ? freq : ((freq << sel) << 1);
      // INT overflows when the top bits already reach the divisor.
      ovf     = (pfd2 == 28'd0) || ({10'b0, vco2[33:16]} >= pfd2);
   end

   // Load the first division state.
   always_comb begin
      item_in.valid = in_valid;
      item_in.oor   = !in_band || ovf;
      item_in.dbl   = dbl;
      item_in.sel   = dbl ? 3'd0 : sel;
      item_in.rem   = {10'b0, vco2[33:16]};
      item_in.num   = vco2[15:0];
      item_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/fnpd_div_step.sv
// One restoring division step: one quotient bit per stage.
// Depends on fnpd_pkg.
module fnpd_div_step
   import fnpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  item_type    item_i,
   input  logic [27:0] pfd2,
   output item_type    item_ff
);

   logic [28:0] trial;
   logic [28:0] diff;
   logic        ge;
   item_type    item_in;

   // Shift in the next numerator bit and subtract the divisor if it fits.
   always_comb begin
      trial = {item_i.rem, item_i.num[15]};
      diff  = trial - {1'b0, pfd2};
      ge    = trial >= {1'b0, pfd2};
      item_in     = item_i;
      item_in.rem = ge ? diff[27:0] : trial[27:0];
      item_in.num = {item_i.num[14:0], 1'b0};
      item_in.quo = {item_i.quo[QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/fnpd_mul.sv
// Scales the FRAC1 leftover by mod2 and sets up the FRAC2 division.
// Depends on fnpd_pkg.
module fnpd_mul
   import fnpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  item_type    item_i,
   input  logic [13:0] mod2,
   output item_type    item_ff
);

   logic [41:0] prod;
   item_type    item_in;

   // The quotient stays below mod2, so the high product bits are a valid remainder.
   always_comb begin
      prod        = {14'b0, item_i.rem} * {28'b0, mod2};
      item_in     = item_i;
      item_in.rem = prod[41:14];
      item_in.num = {prod[13:0], 2'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

endmodule

### tb/sv/fractional_n_pll_divider_calc_tb.sv
// Testbench for fractional_n_pll_divider_calc: drives frequency requests
// under several PFD and mod2 settings and checks each result beat against a
// built-in predictor. Depends on fnpd_pkg and the block's RTL.
module fractional_n_pll_divider_calc_tb;
   import fnpd_pkg::*;

   localparam int FRAC1_W = 24;
   localparam int SETTLE_CYCLES = 100;

   // One expected result beat.
   typedef struct {
      logic [15:0] int_value;
      logic [23:0] frac1;
      logic [13:0] frac2;
      logic [2:0]  divider_select;
      logic        doubler_on;
      logic        feedback_fundamental;
      logic        out_of_range;
      logic [31:0] word_r0;
      logic [31:0] word_r1;
      logic [31:0] word_r2;
   } divider_result_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_PFD_HZ;
   logic [26:0]  csr_wdata = '0;

   // Local copy of the configuration registers.
   logic [26:0] pfd_setting = PFD_HZ_RESET;
   logic [13:0] mod2_setting = MOD2_RESET;

   divider_result_t pending_results[$];
   int  mismatch_count = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  oor_seen = 0;
   int  settings_used = 1;
   bit  steady_mode = 1'b0;
   int  rsp_stall_left = 0;

   fractional_n_pll_divider_calc dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Computes the divider words for one requested frequency.
   function automatic divider_result_t compute_dividers(logic [33:0] freq_hz);
      divider_result_t r;
      longint unsigned f, vco2, pfd2, intv, remv, scaled, f1, left, f2, edge_hz;
      int sel;
      bit dbl;
      r = '{default: '0};
      r.out_of_range = 1'b1;
      f = freq_hz;
      if (f < 64'd53125000 || f > 64'd13600000000) return r;
      dbl = 1'b0;
      sel = 0;
      if (f >= 64'd6800000000) begin
         dbl = 1'b1;
         vco2 = f;
      end else begin
         // Largest divider whose band holds f.
         sel = 6;
         edge_hz = 64'd106250000;
         while (sel > 0 && f >= edge_hz) begin
            sel--;
            edge_hz = edge_hz << 1;
         end
         vco2 = (f << sel) << 1;
      end
      pfd2 = longint'(pfd_setting) << 1;
      if (pfd2 == 0) return r;
      intv = vco2 / pfd2;
      if (intv > 65535) return r;
      remv = vco2 - intv * pfd2;
      scaled = remv << FRAC1_W;
      f1 = scaled / pfd2;
      left = scaled - f1 * pfd2;
      f2 = (left * mod2_setting) / pfd2;
      r.int_value = intv[15:0];
      r.frac1 = f1[23:0];
      r.frac2 = f2[13:0];
      r.divider_select = sel[2:0];
      r.doubler_on = dbl;
      r.feedback_fundamental = ~dbl;
      r.out_of_range = 1'b0;
      r.word_r0 = R0_AUTOCAL | (32'(r.int_value) << 4);
      r.word_r1 = R1_ADDR | (32'(r.frac1) << 4);
      r.word_r2 = R2_ADDR | (32'(mod2_setting) << 4) | (32'(r.frac2) << 18);
      return r;
   endfunction

   // Sends one frequency beat; valid stays high across back-to-back beats.
   task automatic send_frequency(logic [33:0] freq_hz);
      int gap;
      gap = steady_mode ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, freq_hz};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(compute_dividers(freq_hz));
      beats_sent++;
   endtask

   // Waits for the pipeline to drain, then writes one register.
   task automatic write_register(logic idx, logic [26:0] value);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PFD_HZ) pfd_setting = value;
      else mod2_setting = value[13:0];
      settings_used++;
   endtask

   // Result checker and receiver stall generator.
   always @(posedge clock) begin
      divider_result_t exp_r, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.int_value = rsp_tdata[15:0];
            got.frac1 = rsp_tdata[39:16];
            got.frac2 = rsp_tdata[53:40];
            got.divider_select = rsp_tdata[56:54];
            got.doubler_on = rsp_tdata[57];
            got.feedback_fundamental = rsp_tdata[58];
            got.word_r0 = rsp_tdata[90:59];
            got.word_r1 = rsp_tdata[122:91];
            got.word_r2 = rsp_tdata[154:123];
            got.out_of_range = rsp_tuser;
            if (pending_results.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatch_count++;
            end else begin
               exp_r = pending_results.pop_front();
               beats_checked++;
               if (got.out_of_range) oor_seen++;
               if (got.int_value !== exp_r.int_value) begin
                  $error("int_value exp %0d got %0d", exp_r.int_value, got.int_value);
                  mismatch_count++;
               end
               if (got.frac1 !== exp_r.frac1) begin
                  $error("frac1 exp %0d got %0d", exp_r.frac1, got.frac1);
                  mismatch_count++;
               end
               if (got.frac2 !== exp_r.frac2) begin
                  $error("frac2 exp %0d got %0d", exp_r.frac2, got.frac2);
                  mismatch_count++;
               end
               if (got.divider_select !== exp_r.divider_select) begin
                  $error("divider_select exp %0d got %0d",
                         exp_r.divider_select, got.divider_select);
                  mismatch_count++;
               end
               if (got.doubler_on !== exp_r.doubler_on) begin
                  $error("doubler_on exp %0d got %0d", exp_r.doubler_on, got.doubler_on);
                  mismatch_count++;
               end
               if (got.feedback_fundamental !== exp_r.feedback_fundamental) begin
                  $error("feedback_fundamental exp %0d got %0d",
                         exp_r.feedback_fundamental, got.feedback_fundamental);
                  mismatch_count++;
               end
               if (got.out_of_range !== exp_r.out_of_range) begin
                  $error("out_of_range exp %0d got %0d",
                         exp_r.out_of_range, got.out_of_range);
                  mismatch_count++;
               end
               if (got.word_r0 !== exp_r.word_r0) begin
                  $error("word_r0 exp %h got %h", exp_r.word_r0, got.word_r0);
                  mismatch_count++;
               end
               if (got.word_r1 !== exp_r.word_r1) begin
                  $error("word_r1 exp %h got %h", exp_r.word_r1, got.word_r1);
                  mismatch_count++;
               end
               if (got.word_r2 !== exp_r.word_r2) begin
                  $error("word_r2 exp %h got %h", exp_r.word_r2, got.word_r2);
                  mismatch_count++;
               end
            end
            rsp_stall_left = steady_mode ? 0 : $urandom_range(0, 4);
            rsp_tready <= (rsp_stall_left == 0);
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= (rsp_stall_left == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Draws a frequency: mostly inside a random band, sometimes any 34-bit value.
   function automatic logic [33:0] random_frequency();
      longint unsigned lo, span;
      int band;
      if ($urandom_range(0, 9) == 0) return 34'({$urandom, $urandom});
      band = $urandom_range(0, 7);
      lo = 64'd53125000 << band;
      span = (band == 7) ? 64'd6800000000 : lo;
      return 34'(lo + ((longint'({$urandom, $urandom}) & 64'h3_FFFF_FFFF) % (span + 1)));
   endfunction

   task automatic test_band_edges();
      longint unsigned edge_hz;
      send_frequency(34'd0);
      send_frequency(34'd53124999);
      for (int k = 0; k < 8; k++) begin
         edge_hz = 64'd53125000 << k;
         send_frequency(34'(edge_hz));
         send_frequency(34'(edge_hz - 1));
      end
      send_frequency(34'd13600000000);
      send_frequency(34'd13600000001);
      send_frequency(34'h3_FFFF_FFFF);
   endtask

   // Small or zero PFD makes INT overflow everywhere in range.
   task automatic test_int_overflow();
      write_register(CSR_PFD_HZ, 27'd1);
      send_frequency(34'd53125000);
      send_frequency(34'd13600000000);
      write_register(CSR_PFD_HZ, 27'd0);
      send_frequency(34'd1000000000);
   endtask

   task automatic test_config_extremes();
      write_register(CSR_PFD_HZ, 27'd125000000);
      write_register(CSR_MOD2, 27'd0);
      send_frequency(34'd13599999999);
      send_frequency(34'd53125001);
      write_register(CSR_MOD2, 27'h7FF_C001);
      send_frequency(34'd3333333333);
      write_register(CSR_PFD_HZ, 27'h7FF_FFFF);
      write_register(CSR_MOD2, 27'd2);
      send_frequency(34'd7777777777);
      send_frequency(34'd100000007);
   endtask

   task automatic test_random_traffic(int total);
      int per_phase;
      per_phase = total / 6;
      for (int p = 0; p < 6; p++) begin
         if ($urandom_range(0, 4) == 0) begin
            write_register(CSR_PFD_HZ, 27'($urandom_range(1, 300000)));
         end else begin
            write_register(CSR_PFD_HZ, 27'($urandom_range(1000000, 125000000)));
         end
         write_register(CSR_MOD2, (p == 5) ? 27'd16383 : 27'($urandom));
         for (int n = 0; n < per_phase; n++) begin
            steady_mode = (n >= per_phase / 2) && (n < per_phase / 2 + 20);
            send_frequency(random_frequency());
         end
         steady_mode = 1'b0;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_band_edges();
      test_int_overflow();
      test_config_extremes();
      test_random_traffic(600);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d register settings;",
               beats_sent, settings_used);
      $display("%0d results checked, %0d out of range.", beats_checked, oor_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
